// ===== src/i2cbs_pkg.sv =====
// shared types and constants for the i2c master bit sequencer
// no dependencies; used by every module under src
`timescale 1ns / 1ps
`default_nettype none

package i2cbs_pkg;

    localparam int BIT_COUNT      = 8;
    localparam int BIT_IDX_W      = $clog2(BIT_COUNT);
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int S_TDATA_W      = 24;
    localparam int S_TUSER_W      = 3;
    localparam int M_TDATA_W      = 16;

    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_RECV_ACK = 3'd5
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic [7:0] line_sample;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } cmd_push_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

`default_nettype wire

// ===== src/i2cbs_front.sv =====
// input side: unpacks stream items, drops unused operation codes, feeds the command queue
// depends on i2cbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_front (
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [i2cbs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    input  wire logic [i2cbs_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    input  wire logic                                 queue_full,
    output i2cbs_pkg::cmd_push_t                      push
);

    logic op_known;

    assign op_known      = (s_axis_tuser <= i2cbs_pkg::S_TUSER_W'(i2cbs_pkg::OP_RECV_ACK));
    assign s_axis_tready = !queue_full;

    always_comb
    begin
        push.push             = s_axis_tvalid && s_axis_tready && op_known;
        push.cmd.op           = i2cbs_pkg::op_t'(s_axis_tuser);
        push.cmd.tx_byte      = s_axis_tdata[7:0];
        push.cmd.ack_to_send  = s_axis_tdata[8];
        push.cmd.line_sample  = s_axis_tdata[16:9];
    end

endmodule

`default_nettype wire

// ===== src/i2cbs_cmd_fifo.sv =====
// short command queue between the front and the line sequencer
// depends on i2cbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_cmd_fifo #(
    parameter int DEPTH = i2cbs_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2cbs_pkg::cmd_push_t push,
    input  wire logic                 pop,
    output logic                      full,
    output i2cbs_pkg::cmd_head_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    i2cbs_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("command queue over its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty command queue");

    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push.push && !full && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("command queue count did not follow a push");

endmodule

`default_nettype wire

// ===== src/i2cbs_seq.sv =====
// line sequencer: steps each queued command through its scl/sda changes, one per cycle while m_axis is not stalled,
// and holds the result in an output register; depends on i2cbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cbs_seq (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire i2cbs_pkg::cmd_head_t           head,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [i2cbs_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam logic [i2cbs_pkg::BIT_IDX_W-1:0] BIT_LAST =
        i2cbs_pkg::BIT_IDX_W'(i2cbs_pkg::BIT_COUNT - 1);

    logic                              busy_reg;
    i2cbs_pkg::op_t                    op_reg;
    logic [1:0]                        phase_reg;
    logic [i2cbs_pkg::BIT_IDX_W-1:0]   bit_reg;
    logic                              scl_line_reg, sda_line_reg;
    logic                              out_valid_reg;
    logic [7:0]                        tx_reg;
    logic                              ack_reg;
    logic [7:0]                        samp_reg;
    logic                              out_scl_reg, out_sda_reg, out_ack_reg, out_last_reg;
    logic [7:0]                        out_rx_reg;

    logic                              ev_scl, ev_sda, ev_ack, ev_last;
    logic [7:0]                        ev_rx;
    logic [1:0]                        phase_next;
    logic [i2cbs_pkg::BIT_IDX_W-1:0]   bit_next;
    logic [7:0]                        tx_next;
    logic                              advance, load;

    always_comb
    begin
        ev_scl     = scl_line_reg;
        ev_sda     = sda_line_reg;
        ev_rx      = '0;
        ev_ack     = 1'b0;
        ev_last    = 1'b0;
        phase_next = phase_reg + 2'd1;
        bit_next   = bit_reg;
        tx_next    = tx_reg;
        unique case (op_reg)
            i2cbs_pkg::OP_START:
            begin
                case (phase_reg)
                    2'd0:    ev_sda = 1'b1;
                    2'd1:    ev_scl = 1'b1;
                    2'd2:    ev_sda = 1'b0;
                    default:
                    begin
                        ev_scl  = 1'b0;
                        ev_last = 1'b1;
                    end
                endcase
            end
            i2cbs_pkg::OP_STOP:
            begin
                case (phase_reg)
                    2'd0:    ev_sda = 1'b0;
                    2'd1:    ev_scl = 1'b1;
                    default:
                    begin
                        ev_sda  = 1'b1;
                        ev_last = 1'b1;
                    end
                endcase
            end
            i2cbs_pkg::OP_WRITE:
            begin
                case (phase_reg)
                    2'd0:    ev_sda = tx_reg[7];
                    2'd1:    ev_scl = 1'b1;
                    default:
                    begin
                        ev_scl     = 1'b0;
                        ev_last    = (bit_reg == BIT_LAST);
                        phase_next = 2'd0;
                        bit_next   = bit_reg + 1'b1;
                        tx_next    = {tx_reg[6:0], 1'b0};
                    end
                endcase
            end
            i2cbs_pkg::OP_READ:
            begin
                case (phase_reg)
                    2'd0:    ev_sda = 1'b1;
                    2'd1:    ev_scl = 1'b1;
                    default:
                    begin
                        ev_scl     = 1'b0;
                        ev_last    = (bit_reg == BIT_LAST);
                        ev_rx      = ev_last ? samp_reg : 8'h00;
                        phase_next = 2'd1;
                        bit_next   = bit_reg + 1'b1;
                    end
                endcase
            end
            i2cbs_pkg::OP_SEND_ACK:
            begin
                case (phase_reg)
                    2'd0:    ev_sda = ack_reg;
                    2'd1:    ev_scl = 1'b1;
                    default:
                    begin
                        ev_scl  = 1'b0;
                        ev_last = 1'b1;
                    end
                endcase
            end
            i2cbs_pkg::OP_RECV_ACK:
            begin
                case (phase_reg)
                    2'd0:    ev_sda = 1'b1;
                    2'd1:    ev_scl = 1'b1;
                    default:
                    begin
                        ev_scl  = 1'b0;
                        ev_ack  = samp_reg[0];
                        ev_last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                ev_last = 1'b1;
            end
        endcase
    end

    assign advance = busy_reg && (!out_valid_reg || m_axis_tready);
    assign load    = head.valid && (!busy_reg || (advance && ev_last));
    assign pop     = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            op_reg        <= i2cbs_pkg::OP_START;
            phase_reg     <= '0;
            bit_reg       <= '0;
            scl_line_reg  <= 1'b1;
            sda_line_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                scl_line_reg <= ev_scl;
                sda_line_reg <= ev_sda;
                phase_reg    <= phase_next;
                bit_reg      <= bit_next;
                if (ev_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (load)
            begin
                busy_reg  <= 1'b1;
                op_reg    <= head.cmd.op;
                phase_reg <= '0;
                bit_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_reg       <= tx_next;
            out_scl_reg  <= ev_scl;
            out_sda_reg  <= ev_sda;
            out_rx_reg   <= ev_rx;
            out_ack_reg  <= ev_ack;
            out_last_reg <= ev_last;
        end
        if (load)
        begin
            tx_reg   <= head.cmd.tx_byte;
            ack_reg  <= head.cmd.ack_to_send;
            samp_reg <= head.cmd.line_sample;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_ack_reg, out_rx_reg, out_sda_reg, out_scl_reg};

    a_phase3_start_only: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (phase_reg == 2'd3) |-> op_reg == i2cbs_pkg::OP_START)
        else $error("fourth step outside a start command");

    a_fresh_command: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> busy_reg && phase_reg == 2'd0 && bit_reg == '0)
        else $error("loaded command did not start at its first step");

    a_read_release_once: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && op_reg == i2cbs_pkg::OP_READ && phase_reg == 2'd0 |-> bit_reg == '0)
        else $error("read released sda after its first bit");

    a_idle_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |=> $stable(scl_line_reg) && $stable(sda_line_reg))
        else $error("line levels moved while idle");

endmodule

`default_nettype wire

// ===== src/i2c_master_bit_sequencer.sv =====
// top level of the i2c master bit sequencer: front decode, command queue, line sequencer
// depends on i2cbs_pkg, i2cbs_front, i2cbs_cmd_fifo, i2cbs_seq
//
// usage
// - s_axis carries one i2c master command per item; s_axis_tuser is the operation
//   (start, stop, write byte, read byte, send ack, receive ack); codes 6 and 7 are
//   accepted and dropped with no result
// - m_axis carries one item per scl or sda write, giving both line levels after the
//   write; m_axis_tlast marks the final line change of a command, and the read byte
//   or sampled ack rides on that item
// - results per command: start 4, stop 3, write byte 24, read byte 17, ack 3 each
// - when the sequencer is idle, an accepted command passes through the command queue and
//   the sequencer's command registers, then its first line change is registered on m_axis
// - throughput: one line change per cycle, set by the sequencer's step counter, while m_axis
//   is not stalled; the next queued command follows with no gap
// - the command queue holds CMD_FIFO_DEPTH items, so s_axis keeps accepting while
//   the sequencer works; when m_axis stalls the output register holds its item and
//   the sequencer waits, and s_axis_tready drops once the queue fills
// - reset empties the queue and sets both lines to released (high)
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer #(
    parameter int CMD_FIFO_DEPTH = i2cbs_pkg::CMD_FIFO_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tx_byte[7:0], ack_to_send[8], line_sample[16:9], zero [23:17]
    input  wire logic [i2cbs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation[2:0]
    input  wire logic [i2cbs_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // scl_level[0], sda_level[1], rx_byte[9:2], ack_seen[10], zero [15:11]
    output logic [i2cbs_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast
);

    i2cbs_pkg::cmd_push_t push;
    i2cbs_pkg::cmd_head_t head;
    logic                 queue_full;
    logic                 pop;

    i2cbs_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push)
    );

    i2cbs_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (queue_full),
        .head  (head)
    );

    i2cbs_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench for i2c_master_bit_sequencer: a directed command table, then random i2c transactions
// every line change is checked against an in-bench model of the scl and sda levels
// depends on i2cbs_pkg and the rtl under src

module testbench;

    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;
    localparam logic SCL_LINE = 1'b1;
    localparam logic SDA_LINE = 1'b0;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int ITEMS_PER_PHASE = 33;

    typedef struct {
        logic       scl;
        logic       sda;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       last;
    } line_change_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic [7:0] line_sample;
        logic       typed;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } command_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tx_byte[7:0], ack_to_send[8], line_sample[16:9], zero [23:17]
    logic [23:0] s_axis_tdata = '0;
    // operation[2:0]
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // scl_level[0], sda_level[1], rx_byte[9:2], ack_seen[10], zero [15:11]
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic         scl_now = 1'b1;
    logic         sda_now = 1'b1;
    line_change_t line_changes_due[$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           hold_left = 0;
    logic         hold_request = 1'b0;

    int idle_by_phase[4]  = '{0, 48, 0, 25};
    int stall_by_phase[4] = '{0, 0, 48, 25};

    // op, tx_byte, ack_to_send, line_sample, typed, rx_byte, ack_seen
    command_row_t directed_rows[24] = '{
        '{i2cbs_pkg::OP_START,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_WRITE,    8'hff, 1'b1, 8'hff, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_RECV_ACK, 8'h00, 1'b0, 8'h01, 1'b1, 8'h00, 1'b1},
        '{i2cbs_pkg::OP_WRITE,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_RECV_ACK, 8'hff, 1'b1, 8'hfe, 1'b1, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_WRITE,    8'ha5, 1'b0, 8'h5a, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_READ,     8'h00, 1'b0, 8'hff, 1'b1, 8'hff, 1'b0},
        '{i2cbs_pkg::OP_SEND_ACK, 8'hff, 1'b0, 8'hff, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_READ,     8'hff, 1'b1, 8'h00, 1'b1, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_SEND_ACK, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_READ,     8'h00, 1'b0, 8'h5a, 1'b1, 8'h5a, 1'b0},
        '{OP_UNUSED_6,            8'hff, 1'b1, 8'hff, 1'b0, 8'h00, 1'b0},
        '{OP_UNUSED_7,            8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_STOP,     8'hff, 1'b1, 8'hff, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_STOP,     8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_START,    8'hff, 1'b1, 8'hff, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_START,    8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_WRITE,    8'h80, 1'b1, 8'h7f, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_RECV_ACK, 8'h00, 1'b0, 8'hff, 1'b1, 8'h00, 1'b1},
        '{i2cbs_pkg::OP_READ,     8'h00, 1'b1, 8'h01, 1'b1, 8'h01, 1'b0},
        '{i2cbs_pkg::OP_SEND_ACK, 8'hff, 1'b0, 8'hff, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_STOP,     8'h00, 1'b0, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_WRITE,    8'h7f, 1'b0, 8'h80, 1'b0, 8'h00, 1'b0},
        '{i2cbs_pkg::OP_RECV_ACK, 8'h00, 1'b0, 8'h00, 1'b1, 8'h00, 1'b0}
    };

    i2c_master_bit_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic line_change_t line_write(input logic which, input logic level,
            input logic [7:0] rx_byte, input logic ack_seen, input logic last);
        line_change_t change;
        if (which == SCL_LINE)
            scl_now = level;
        else
            sda_now = level;
        change.scl      = scl_now;
        change.sda      = sda_now;
        change.rx_byte  = rx_byte;
        change.ack_seen = ack_seen;
        change.last     = last;
        return change;
    endfunction

    task automatic predict_line_changes(input command_row_t row);
        logic [7:0] assembled;
        logic       ack_level;
        assembled = 8'h00;
        ack_level = row.typed ? row.ack_seen : row.line_sample[0];
        case (row.op)
            i2cbs_pkg::OP_START:
            begin
                line_changes_due.push_back(line_write(SDA_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SDA_LINE, 1'b0, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b0, 8'h00, 1'b0, 1'b1));
            end
            i2cbs_pkg::OP_STOP:
            begin
                line_changes_due.push_back(line_write(SDA_LINE, 1'b0, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SDA_LINE, 1'b1, 8'h00, 1'b0, 1'b1));
            end
            i2cbs_pkg::OP_WRITE:
            begin
                for (int i = 7; i >= 0; i--)
                begin
                    line_changes_due.push_back(
                        line_write(SDA_LINE, row.tx_byte[i], 8'h00, 1'b0, 1'b0));
                    line_changes_due.push_back(line_write(SCL_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                    line_changes_due.push_back(
                        line_write(SCL_LINE, 1'b0, 8'h00, 1'b0, i == 0));
                end
            end
            i2cbs_pkg::OP_READ:
            begin
                line_changes_due.push_back(line_write(SDA_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                for (int i = 7; i >= 0; i--)
                begin
                    line_changes_due.push_back(line_write(SCL_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                    assembled[i] = row.line_sample[i];
                    if (i == 0)
                        line_changes_due.push_back(line_write(SCL_LINE, 1'b0,
                            row.typed ? row.rx_byte : assembled, 1'b0, 1'b1));
                    else
                        line_changes_due.push_back(
                            line_write(SCL_LINE, 1'b0, 8'h00, 1'b0, 1'b0));
                end
            end
            i2cbs_pkg::OP_SEND_ACK:
            begin
                line_changes_due.push_back(
                    line_write(SDA_LINE, row.ack_to_send, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b0, 8'h00, 1'b0, 1'b1));
            end
            i2cbs_pkg::OP_RECV_ACK:
            begin
                line_changes_due.push_back(line_write(SDA_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b1, 8'h00, 1'b0, 1'b0));
                line_changes_due.push_back(line_write(SCL_LINE, 1'b0, 8'h00, ack_level, 1'b1));
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_command(input command_row_t row);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.op;
        s_axis_tdata  <= {7'b0, row.line_sample, row.ack_to_send, row.tx_byte};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_line_changes(row);
        items_sent++;
    endtask

    task automatic send_random_op(input logic [2:0] op);
        command_row_t row;
        row.op          = op;
        row.tx_byte     = 8'($urandom_range(0, 255));
        row.ack_to_send = 1'($urandom_range(0, 1));
        row.line_sample = 8'($urandom_range(0, 255));
        row.typed       = 1'b0;
        row.rx_byte     = 8'h00;
        row.ack_seen    = 1'b0;
        send_command(row);
    endtask

    task automatic send_transactions(input int count);
        int stop_at;
        int transfers;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 3) == 0)
                send_random_op(3'($urandom_range(0, 7)));
            else
            begin
                send_random_op(i2cbs_pkg::OP_START);
                send_random_op(i2cbs_pkg::OP_WRITE);
                send_random_op(i2cbs_pkg::OP_RECV_ACK);
                transfers = $urandom_range(1, 3);
                repeat (transfers)
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        send_random_op(i2cbs_pkg::OP_WRITE);
                        send_random_op(i2cbs_pkg::OP_RECV_ACK);
                    end
                    else
                    begin
                        send_random_op(i2cbs_pkg::OP_READ);
                        send_random_op(i2cbs_pkg::OP_SEND_ACK);
                    end
                end
                // some transactions end without a stop
                if ($urandom_range(0, 9) != 0)
                    send_random_op(i2cbs_pkg::OP_STOP);
            end
        end
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (line_changes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic compare_field(input string field, input int unsigned want,
            input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : line_change_check
        line_change_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (line_changes_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected line change, expected none, actual tdata %0h tlast %0b",
                    $time, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = line_changes_due.pop_front();
                compare_field("scl_level", want.scl, m_axis_tdata[0]);
                compare_field("sda_level", want.sda, m_axis_tdata[1]);
                compare_field("rx_byte", want.rx_byte, m_axis_tdata[9:2]);
                compare_field("ack_seen", want.ack_seen, m_axis_tdata[10]);
                compare_field("last_event", want.last, m_axis_tlast);
            end
        end
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_command(directed_rows[i]);
        wait_until_drained();
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_by_phase[phase];
            stall_pct     = stall_by_phase[phase];
            // long receiver hold-off so the command queue fills and stalls the input
            if (phase == 0 || phase == 3)
                hold_request = 1'b1;
            send_transactions(ITEMS_PER_PHASE);
            wait_until_drained();
        end
        if (mismatches == 0)
            $display("i2c_master_bit_sequencer test passed");
        else
            $display("i2c_master_bit_sequencer test failed");
        $finish;
    end

    initial
    begin
        #3ms;
        $display("i2c_master_bit_sequencer test failed");
        $finish;
    end

endmodule
